// ===== rtl/mts_pkg.sv =====
// Shared types and codes for the min tracking stack.
// Used by mts_ctrl, mts_datapath and min_tracking_stack; depends on nothing.
package mts_pkg;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic push;
    logic pop_start;
    logic pop_done;
  } cmd_t;

endpackage

// ===== rtl/mts_datapath.sv =====
// Datapath of the min tracking stack: value and minimum stores, counts, cached
// minimum top and the result register. Driven by mts_ctrl through mts_pkg::cmd_t.
module mts_datapath #(
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mts_pkg::cmd_t         cmd_i,
  input  logic [DATA_WIDTH-1:0] data_value_i,
  output logic [DATA_WIDTH-1:0] popped_value_o,
  output logic [DATA_WIDTH-1:0] current_min_o,
  output logic                  now_empty_o,
  output logic                  overflow_o,
  output logic                  underflow_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [DATA_WIDTH-1:0] val_mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] min_mem [STACK_DEPTH];

  logic [CW-1:0]         vcount_q, vcount_d;
  logic [CW-1:0]         mcount_q, mcount_d;
  logic [DATA_WIDTH-1:0] min_top_q, min_top_d;
  logic [DATA_WIDTH-1:0] val_rd_q;
  logic [DATA_WIDTH-1:0] min_rd_q;
  logic                  unf_pend_q;

  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  logic [DATA_WIDTH-1:0] cmin_q, cmin_d;
  logic                  empty_q, empty_d;
  logic                  ovf_q, ovf_d;
  logic                  unf_q, unf_d;

  logic                  full;
  logic                  push_val;
  logic                  push_min;
  logic                  load;
  logic [CW-1:0]         vdec;
  logic [CW-1:0]         mnext;

  assign full  = (vcount_q == CW'(STACK_DEPTH));
  assign vdec  = vcount_q - CW'(1);
  assign mnext = mcount_q - CW'(2);
  assign load  = cmd_i.push | cmd_i.pop_done;

  always_comb begin
    vcount_d  = vcount_q;
    mcount_d  = mcount_q;
    min_top_d = min_top_q;
    popped_d  = '1;
    ovf_d     = 1'b0;
    unf_d     = 1'b0;
    push_val  = 1'b0;
    push_min  = 1'b0;
    if (cmd_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        push_val = 1'b1;
        vcount_d = vcount_q + CW'(1);
        if ((mcount_q == '0) || ($signed(data_value_i) <= $signed(min_top_q))) begin
          push_min  = 1'b1;
          mcount_d  = mcount_q + CW'(1);
          min_top_d = data_value_i;
        end
      end
    end
    if (cmd_i.pop_start && (vcount_q != '0)) begin
      vcount_d = vdec;
    end
    if (cmd_i.pop_done) begin
      if (unf_pend_q) begin
        unf_d = 1'b1;
      end else begin
        popped_d = val_rd_q;
        if ((mcount_q != '0) && (val_rd_q == min_top_q)) begin
          mcount_d  = mcount_q - CW'(1);
          min_top_d = min_rd_q;
        end
      end
    end
    empty_d = (vcount_d == '0);
    cmin_d  = empty_d ? '1 : min_top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= '0;
      mcount_q   <= '0;
      unf_pend_q <= 1'b0;
    end else begin
      vcount_q <= vcount_d;
      mcount_q <= mcount_d;
      if (cmd_i.pop_start) begin
        unf_pend_q <= (vcount_q == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_top_q <= min_top_d;
    if (load) begin
      popped_q <= popped_d;
      cmin_q   <= cmin_d;
      empty_q  <= empty_d;
      ovf_q    <= ovf_d;
      unf_q    <= unf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_val) begin
      val_mem[vcount_q[AW-1:0]] <= data_value_i;
    end
    if (push_min) begin
      min_mem[mcount_q[AW-1:0]] <= data_value_i;
    end
    if (cmd_i.pop_start) begin
      val_rd_q <= val_mem[vdec[AW-1:0]];
      min_rd_q <= min_mem[mnext[AW-1:0]];
    end
  end

  assign popped_value_o = popped_q;
  assign current_min_o  = cmin_q;
  assign now_empty_o    = empty_q;
  assign overflow_o     = ovf_q;
  assign underflow_o    = unf_q;

endmodule

// ===== rtl/mts_ctrl.sv =====
// Controller of the min tracking stack: request handshakes, pop sequencing and
// result valid. Issues mts_pkg::cmd_t commands to mts_datapath.
module mts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_kind_i,
  output logic          req_ready_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output mts_pkg::cmd_t cmd_o
);

  mts_pkg::state_e state_q, state_d;
  logic            res_valid_q, res_valid_d;
  logic            out_free;
  logic            accept;

  assign out_free = !res_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    accept      = 1'b0;
    res_valid_d = res_valid_q && !res_ready_i;
    case (state_q)
      mts_pkg::ST_IDLE: begin
        req_ready_o = out_free;
        accept      = req_valid_i && out_free;
        if (accept) begin
          if (req_kind_i == mts_pkg::KIND_POP) begin
            cmd_o.pop_start = 1'b1;
            state_d         = mts_pkg::ST_POP;
          end else begin
            cmd_o.push  = 1'b1;
            res_valid_d = 1'b1;
          end
        end
      end
      mts_pkg::ST_POP: begin
        if (out_free) begin
          cmd_o.pop_done = 1'b1;
          res_valid_d    = 1'b1;
          state_d        = mts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mts_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;

endmodule

// ===== rtl/min_tracking_stack.sv =====
// Min tracking stack: a LIFO of signed values that reports its minimum each step.
// Top level; instantiates mts_ctrl and mts_datapath, uses types from mts_pkg.
//
// Requests enter on the s_axis group: tuser[0] is the kind (0 push, 1 pop) and
// tdata carries the value to push. Each request gives exactly one result on the
// m_axis group: popped value, minimum after the step (all ones when empty),
// and the empty, overflow and underflow flags.
// A push's result is valid in the cycle after acceptance.
// A pop first does a synchronous read of the value and minimum stores,
// then the compare against the cached minimum top and the write-back.
// One push per cycle while results are not stalled; a pop blocks requests until
// its compare step, set by the read port; one request is in flight at a time.
// Reset empties both stacks at once; the stores need no clearing.
// A stalled result holds in the output register; a new request is accepted
// only when that register is free or being taken in the same cycle.
// A push to a full stack changes nothing and flags overflow; a pop of an empty
// stack flags underflow and returns all ones.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 32,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // data_value
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata_i,
  // kind
  input  logic [0:0]                             s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // popped_value, current_min, now_empty, overflow, underflow, zero fill
  output logic [((2*DATA_WIDTH+3+7)/8)*8-1:0]     m_axis_tdata_o
);

  localparam int OUT_TW = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8;
  localparam int OUT_PW = OUT_TW - (2 * DATA_WIDTH + 3);

  mts_pkg::cmd_t         cmd;
  logic [DATA_WIDTH-1:0] popped_value;
  logic [DATA_WIDTH-1:0] current_min;
  logic                  now_empty;
  logic                  overflow;
  logic                  underflow;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_kind_i  (s_axis_tuser_i[0]),
    .req_ready_o (s_axis_tready_o),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_value_i   (s_axis_tdata_i[DATA_WIDTH-1:0]),
    .popped_value_o (popped_value),
    .current_min_o  (current_min),
    .now_empty_o    (now_empty),
    .overflow_o     (overflow),
    .underflow_o    (underflow)
  );

  generate
    if (OUT_PW > 0) begin : g_pad
      assign m_axis_tdata_o = {{OUT_PW{1'b0}}, underflow, overflow, now_empty,
                               current_min, popped_value};
    end else begin : g_nopad
      assign m_axis_tdata_o = {underflow, overflow, now_empty, current_min, popped_value};
    end
  endgenerate

  a_pop_blocks_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == mts_pkg::KIND_POP))
    |=> !s_axis_tready_o)
    else $error("request accepted in the cycle after a pop");

  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == mts_pkg::KIND_PUSH))
    |=> m_axis_tvalid_o)
    else $error("push gave no result in the next cycle");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(overflow && underflow))
    else $error("overflow and underflow both set");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && now_empty) |-> (current_min == '1))
    else $error("empty stack reports a minimum");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && underflow) |-> (now_empty && (popped_value == '1)))
    else $error("underflow result inconsistent");

endmodule

// ===== dv/min_tracking_stack_tb.sv =====
// Self-checking testbench for min_tracking_stack: push and pop requests on the
// s_axis group, results checked field by field against an in-bench stack model.
// Depends on mts_pkg and the min_tracking_stack RTL.
module min_tracking_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH  = 32;
  localparam int DATA_WIDTH   = 32;
  localparam int TDATA_W      = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int RDATA_W      = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t popped;
    word_t cur_min;
    logic  empty;
    logic  ovf;
    logic  unf;
  } step_result_t;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_valid  = 1'b0;
  logic [TDATA_W-1:0] s_data   = '0;
  logic [0:0]         s_user   = '0;
  logic               m_ready  = 1'b0;
  wire                s_ready;
  wire                m_valid;
  wire [RDATA_W-1:0]  m_data;

  word_t       value_stack [STACK_DEPTH];
  word_t       min_stack   [STACK_DEPTH];
  int unsigned depth     = 0;
  int unsigned min_depth = 0;

  step_result_t expected_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  int error_count = 0;
  int n_push      = 0;
  int n_pop       = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int n_checked   = 0;

  min_tracking_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic step_result_t stack_step(mts_pkg::kind_e kind, word_t value);
    step_result_t r;
    r.popped = '1;
    r.ovf    = 1'b0;
    r.unf    = 1'b0;
    if (kind == mts_pkg::KIND_PUSH) begin
      if (depth >= STACK_DEPTH) begin
        r.ovf = 1'b1;
      end else begin
        if (min_depth == 0 || value <= min_stack[min_depth-1]) begin
          if (min_depth < STACK_DEPTH) begin
            min_stack[min_depth] = value;
            min_depth++;
          end
        end
        value_stack[depth] = value;
        depth++;
      end
    end else if (depth == 0) begin
      r.unf = 1'b1;
    end else begin
      depth--;
      r.popped = value_stack[depth];
      if (min_depth > 0 && r.popped == min_stack[min_depth-1]) min_depth--;
    end
    r.empty   = (depth == 0);
    r.cur_min = (depth == 0 || min_depth == 0) ? word_t'('1) : min_stack[min_depth-1];
    return r;
  endfunction

  function automatic word_t pick_value();
    word_t v;
    int    delta;
    delta = int'($urandom_range(2)) - 1;
    case ($urandom_range(9))
      0, 1, 2, 3: v = word_t'($urandom_range(16)) - 8;
      4: begin
        case ($urandom_range(3))
          0:       v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
          1:       v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
          2:       v = '1;
          default: v = '0;
        endcase
      end
      5:       v = (min_depth > 0) ? min_stack[min_depth-1] + word_t'(delta) : '0;
      default: v = word_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_request(mts_pkg::kind_e kind, word_t value);
    step_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      s_data  <= $urandom;
      s_user  <= 1'($urandom);
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_user  <= kind;
    do @(posedge clk_i); while (!s_ready);
    r = stack_step(kind, value);
    expected_results.push_back(r);
    if (kind == mts_pkg::KIND_PUSH) begin
      n_push++;
      n_full += r.ovf;
    end else begin
      n_pop++;
      n_empty += r.unf;
    end
  endtask

  task automatic check_result(logic [RDATA_W-1:0] bus);
    step_result_t exp;
    step_result_t act;
    act.popped  = bus[DATA_WIDTH-1:0];
    act.cur_min = bus[2*DATA_WIDTH-1:DATA_WIDTH];
    act.empty   = bus[2*DATA_WIDTH];
    act.ovf     = bus[2*DATA_WIDTH+1];
    act.unf     = bus[2*DATA_WIDTH+2];
    if (expected_results.size() == 0) begin
      $error("result with no request pending: tdata %h", bus);
      error_count++;
    end else begin
      exp = expected_results.pop_front();
      n_checked++;
      if (act.popped !== exp.popped) begin
        $error("popped_value: expected %0d, got %0d", exp.popped, act.popped);
        error_count++;
      end
      if (act.cur_min !== exp.cur_min) begin
        $error("current_min: expected %0d, got %0d", exp.cur_min, act.cur_min);
        error_count++;
      end
      if (act.empty !== exp.empty) begin
        $error("now_empty: expected %0b, got %0b", exp.empty, act.empty);
        error_count++;
      end
      if (act.ovf !== exp.ovf) begin
        $error("overflow: expected %0b, got %0b", exp.ovf, act.ovf);
        error_count++;
      end
      if (act.unf !== exp.unf) begin
        $error("underflow: expected %0b, got %0b", exp.unf, act.unf);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) check_result(m_data);
    m_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results pending", cycle_count,
             expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(mts_pkg::KIND_POP,  '0);
    send_request(mts_pkg::KIND_PUSH, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    send_request(mts_pkg::KIND_PUSH, word_t'(5));
    send_request(mts_pkg::KIND_PUSH, word_t'(5));
    send_request(mts_pkg::KIND_PUSH, word_t'(7));
    send_request(mts_pkg::KIND_PUSH, '1);
    send_request(mts_pkg::KIND_PUSH, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    send_request(mts_pkg::KIND_PUSH, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    send_request(mts_pkg::KIND_PUSH, '0);
    repeat (8) send_request(mts_pkg::KIND_POP, '1);
    send_request(mts_pkg::KIND_POP,  '1);
    send_request(mts_pkg::KIND_PUSH, '1);
    send_request(mts_pkg::KIND_PUSH, word_t'(3));
    send_request(mts_pkg::KIND_POP,  '0);
    send_request(mts_pkg::KIND_POP,  '0);
  endtask

  task automatic test_overflow();
    int fill;
    fill = STACK_DEPTH - int'(depth);
    repeat (fill) send_request(mts_pkg::KIND_PUSH, pick_value());
    send_request(mts_pkg::KIND_PUSH, {1'b1, {(DATA_WIDTH-1){1'b0}}});
    send_request(mts_pkg::KIND_PUSH, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    send_request(mts_pkg::KIND_PUSH, '1);
    repeat (STACK_DEPTH + 2) send_request(mts_pkg::KIND_POP, pick_value());
  endtask

  task automatic test_random(int tx_pct, int rx_pct, int count);
    int target;
    int push_pct;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    target      = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0:       target = 0;
          1:       target = STACK_DEPTH + 2;
          default: target = $urandom_range(STACK_DEPTH, 1);
        endcase
      end
      if (int'(depth) < target)      push_pct = 80;
      else if (int'(depth) > target) push_pct = 20;
      else                           push_pct = 50;
      send_request(($urandom_range(99) < push_pct) ? mts_pkg::KIND_PUSH : mts_pkg::KIND_POP,
                   pick_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 26;
    rx_idle_pct = 48;
    test_directed();
    test_overflow();
    test_random(26, 48, 420);
    test_random(48, 26, 420);
    test_random(0, 0, 420);
    s_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d pushes (%0d refused on a full stack) and %0d pops (%0d on empty).",
             n_push, n_full, n_pop, n_empty);
    $display("Checked %0d results, %0d field mismatches.", n_checked, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== min_tracking_stack.f =====
rtl/mts_pkg.sv
rtl/mts_datapath.sv
rtl/mts_ctrl.sv
rtl/min_tracking_stack.sv
dv/min_tracking_stack_tb.sv
